// ===== rtl/nanc_pkg.sv =====
`timescale 1ns / 1ps
package nanc_pkg;

    localparam int TAP_COUNT_DEF = 32;
    localparam logic signed [15:0] STEP_RESET = 16'sd33;
    // Magnitude of step * error * tap is at most 2**45.
    localparam int DVD_W = 46;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RB,
        ST_FIR_RD,
        ST_FIR_MUL,
        ST_FIR_ACC,
        ST_ERR,
        ST_SE,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_UPD_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic push;
        logic coef_wr;
        logic coef_rd;
        logic rb_cap;
        logic fir_mul;
        logic fir_acc;
        logic err_calc;
        logic se_mul;
        logic upd_mul;
        logic div_init;
        logic div_step;
        logic upd_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_ok;
        logic       norm_zero;
    } t_dp_sts;

endpackage

// ===== rtl/nanc_in_if.sv =====
`timescale 1ns / 1ps
interface nanc_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic signed [15:0] signal_sample;
    logic signed [15:0] noise_sample;
    logic        [7:0]  coef_index;
    logic signed [15:0] coef_value;

    modport source (output valid, cmd, signal_sample, noise_sample, coef_index, coef_value,
                    input ready);
    modport sink (input valid, cmd, signal_sample, noise_sample, coef_index, coef_value,
                  output ready);
endinterface

// ===== rtl/nanc_out_if.sv =====
`timescale 1ns / 1ps
interface nanc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] error_out;
    logic signed [15:0] coef_readback;

    modport source (output valid, error_out, coef_readback, input ready);
    modport sink (input valid, error_out, coef_readback, output ready);
endinterface

// ===== rtl/nlms_adaptive_noise_canceller_top.sv =====
`timescale 1ns / 1ps
// An accepted sample word runs the filter pass over every tap, the error and the step-error
// product, then per coefficient a read, a multiply, a serial restoring divide and a write-back;
// a zero norm skips the update pass. Write, read and unused words skip the filter pass.
// Throughput: one word at a time; the next is accepted in the cycle after the result is loaded,
// and a full output register can stall that load.
// Reset (synchronous, active low) sets the step to 33, then clears both RAMs.
module nlms_adaptive_noise_canceller_top #(
    parameter int TAP_COUNT = nanc_pkg::TAP_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_data,
    nanc_in_if.sink            i_in,
    nanc_out_if.source         o_out
);
    import nanc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic [$clog2(TAP_COUNT)-1:0] tap;

    // The controller sequences the filter pass, the error, and the per-coefficient
    // multiply, divide and write-back; the output word sits in its own register so the
    // next input word can be taken while a result still waits downstream.
    nanc_ctrl #(.TAP_COUNT(TAP_COUNT)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_tap       (tap)
    );

    // The datapath holds the history ring and coefficient RAMs, the accumulators and
    // the restoring divider.
    nanc_datapath #(.TAP_COUNT(TAP_COUNT)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_tap           (tap),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd_code      (i_in.cmd),
        .i_signal_sample (i_in.signal_sample),
        .i_noise_sample  (i_in.noise_sample),
        .i_coef_index    (i_in.coef_index),
        .i_coef_value    (i_in.coef_value),
        .o_sts           (sts),
        .o_error_out     (o_out.error_out),
        .o_coef_readback (o_out.coef_readback)
    );
endmodule

// ===== rtl/nanc_ram.sv =====
`timescale 1ns / 1ps
module nanc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/nanc_ctrl.sv =====
`timescale 1ns / 1ps
module nanc_ctrl #(
    parameter int TAP_COUNT = nanc_pkg::TAP_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  nanc_pkg::t_dp_sts            i_sts,
    output nanc_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(TAP_COUNT)-1:0] o_tap
);
    import nanc_pkg::*;

    localparam int TAP_W = $clog2(TAP_COUNT);
    localparam int DCNT_W = $clog2(DVD_W);
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DVD_W - 1);

    t_state r_state, n_state;
    logic [TAP_W-1:0] r_tap, n_tap;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_tap    <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tap    <= n_tap;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_tap      = r_tap;
        n_dcnt     = r_dcnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_tap   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_tap = '0;
                case (i_sts.cmd)
                    CMD_SAMPLE: begin
                        o_cmd.push = 1'b1;
                        n_state    = ST_FIR_RD;
                    end
                    CMD_WRITE: begin
                        o_cmd.coef_wr = 1'b1;
                        n_state       = ST_DONE;
                    end
                    CMD_READ: begin
                        o_cmd.coef_rd = 1'b1;
                        n_state       = ST_RB;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_RB: begin
                o_cmd.rb_cap = 1'b1;
                n_state      = ST_DONE;
            end
            ST_FIR_RD: n_state = ST_FIR_MUL;
            ST_FIR_MUL: begin
                o_cmd.fir_mul = 1'b1;
                n_state       = ST_FIR_ACC;
            end
            ST_FIR_ACC: begin
                o_cmd.fir_acc = 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_state = ST_ERR;
                end else begin
                    n_tap   = r_tap + 1'b1;
                    n_state = ST_FIR_RD;
                end
            end
            ST_ERR: begin
                o_cmd.err_calc = 1'b1;
                n_state        = ST_SE;
            end
            ST_SE: begin
                o_cmd.se_mul = 1'b1;
                n_tap        = '0;
                n_state      = i_sts.norm_zero ? ST_DONE : ST_UPD_RD;
            end
            ST_UPD_RD: n_state = ST_UPD_MUL;
            ST_UPD_MUL: begin
                o_cmd.upd_mul = 1'b1;
                n_state       = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_dcnt         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_dcnt == DIV_LAST) begin
                    n_state = ST_UPD_WR;
                end else begin
                    n_dcnt = r_dcnt + 1'b1;
                end
            end
            ST_UPD_WR: begin
                o_cmd.upd_wr = 1'b1;
                if (r_tap == TAP_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_tap   = r_tap + 1'b1;
                    n_state = ST_UPD_RD;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_tap       = r_tap;
endmodule

// ===== rtl/nanc_datapath.sv =====
`timescale 1ns / 1ps
module nanc_datapath #(
    parameter int TAP_COUNT = nanc_pkg::TAP_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nanc_pkg::t_dp_cmd            i_cmd,
    input  logic [$clog2(TAP_COUNT)-1:0] i_tap,
    input  logic                         i_cfg_we,
    input  logic signed [15:0]           i_cfg_data,
    input  logic [1:0]                   i_cmd_code,
    input  logic signed [15:0]           i_signal_sample,
    input  logic signed [15:0]           i_noise_sample,
    input  logic [7:0]                   i_coef_index,
    input  logic signed [15:0]           i_coef_value,
    output nanc_pkg::t_dp_sts            o_sts,
    output logic signed [15:0]           o_error_out,
    output logic signed [15:0]           o_coef_readback
);
    import nanc_pkg::*;

    localparam int TAP_W = $clog2(TAP_COUNT);
    localparam int ACC_W = 32 + TAP_W;
    localparam int SQ_W  = 31 + TAP_W;
    localparam int NRM_W = SQ_W - 16;
    localparam int PRD_W = DVD_W + 1;
    localparam logic [TAP_W:0] DEPTH = (TAP_W + 1)'(TAP_COUNT);
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);
    localparam logic [8:0] IDX_LIM = 9'(TAP_COUNT);

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    logic [1:0]              r_cmd;
    logic signed [15:0]      r_sig, r_noise, r_val, r_step;
    logic [7:0]              r_idx;
    logic [TAP_W-1:0]        r_hp;
    logic signed [31:0]      r_pc;
    logic [30:0]             r_ps;
    logic signed [ACC_W-1:0] r_acc;
    logic [SQ_W-1:0]         r_sq;
    logic signed [15:0]      r_err, r_rb, r_coef, r_out_err, r_out_rb;
    logic [NRM_W-1:0]        r_norm, r_rem;
    logic signed [31:0]      r_se;
    logic signed [PRD_W-1:0] r_prod;
    logic                    r_neg;
    logic [DVD_W-1:0]        r_q;

    logic                    idx_ok;
    logic [TAP_W-1:0]        hp_next;
    logic [TAP_W:0]          hsum;
    logic [TAP_W-1:0]        h_raddr, h_waddr, c_raddr, c_waddr;
    logic                    h_we, c_we;
    logic signed [15:0]      h_wdata, c_wdata, h_rd, c_rd;
    logic signed [31:0]      sq_full;
    logic signed [47:0]      prod_full;
    logic signed [ACC_W-1:0] est_full;
    logic signed [15:0]      est16;
    logic signed [16:0]      diff;
    logic [NRM_W:0]          rem_sh;
    logic                    ge;
    logic signed [PRD_W-1:0] mag, qs, qsh;
    logic signed [PRD_W:0]   upd_sum;
    logic signed [15:0]      new_coef;

    assign idx_ok  = {1'b0, r_idx} < IDX_LIM;
    assign hp_next = (r_hp == TAP_LAST) ? '0 : r_hp + 1'b1;

    // Coefficient k meets the history entry just past the newest one, plus k.
    always_comb begin
        hsum = {1'b0, r_hp} + (TAP_W + 1)'(1) + {1'b0, i_tap};
        if (hsum >= DEPTH) begin
            hsum = hsum - DEPTH;
        end
        h_raddr = hsum[TAP_W-1:0];
    end

    assign c_raddr = i_cmd.coef_rd ? r_idx[TAP_W-1:0] : i_tap;

    always_comb begin
        h_we    = i_cmd.clr | i_cmd.push;
        h_waddr = i_cmd.clr ? i_tap : hp_next;
        h_wdata = i_cmd.clr ? 16'sd0 : r_noise;
        c_we    = i_cmd.clr | i_cmd.upd_wr | (i_cmd.coef_wr & idx_ok);
        c_waddr = i_cmd.coef_wr ? r_idx[TAP_W-1:0] : i_tap;
        if (i_cmd.clr) begin
            c_wdata = 16'sd0;
        end else if (i_cmd.coef_wr) begin
            c_wdata = r_val;
        end else begin
            c_wdata = new_coef;
        end
    end

    nanc_ram #(.WIDTH(16), .DEPTH(TAP_COUNT)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rd)
    );

    nanc_ram #(.WIDTH(16), .DEPTH(TAP_COUNT)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rd)
    );

    assign sq_full   = h_rd * h_rd;
    assign prod_full = r_se * h_rd;
    assign est_full  = r_acc >>> 16;
    assign est16     = sat16(64'(est_full));
    assign diff      = 17'(r_sig) - 17'(est16);
    assign rem_sh    = {r_rem, r_q[DVD_W-1]};
    assign ge        = rem_sh >= {1'b0, r_norm};
    assign mag       = r_prod[PRD_W-1] ? -r_prod : r_prod;
    assign qs        = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign qsh       = qs >>> 14;
    assign upd_sum   = (PRD_W + 1)'(qsh) + (PRD_W + 1)'(r_coef);
    assign new_coef  = sat16(64'(upd_sum));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp   <= '0;
            r_step <= STEP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_data;
            end
            if (i_cmd.push) begin
                r_hp <= hp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_cmd_code;
            r_sig   <= i_signal_sample;
            r_noise <= i_noise_sample;
            r_idx   <= i_coef_index;
            r_val   <= i_coef_value;
            r_acc   <= '0;
            r_sq    <= '0;
            r_err   <= '0;
            r_rb    <= '0;
        end
        if (i_cmd.rb_cap && idx_ok) begin
            r_rb <= c_rd;
        end
        if (i_cmd.fir_mul) begin
            r_pc <= c_rd * h_rd;
            r_ps <= sq_full[30:0];
        end
        if (i_cmd.fir_acc) begin
            r_acc <= r_acc + ACC_W'(r_pc);
            r_sq  <= r_sq + SQ_W'(r_ps);
        end
        if (i_cmd.err_calc) begin
            r_err  <= sat16(64'(diff));
            r_norm <= r_sq[SQ_W-1:16];
        end
        if (i_cmd.se_mul) begin
            r_se <= r_step * r_err;
        end
        if (i_cmd.upd_mul) begin
            r_prod <= prod_full[PRD_W-1:0];
            r_coef <= c_rd;
        end
        if (i_cmd.div_init) begin
            r_neg <= r_prod[PRD_W-1];
            r_q   <= mag[DVD_W-1:0];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? NRM_W'(rem_sh - {1'b0, r_norm}) : rem_sh[NRM_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out_err <= r_err;
            r_out_rb  <= r_rb;
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.idx_ok    = idx_ok;
    assign o_sts.norm_zero = (r_norm == '0);
    assign o_error_out     = r_out_err;
    assign o_coef_readback = r_out_rb;
endmodule

// ===== rtl/nanc_checker.sv =====
`timescale 1ns / 1ps
module nanc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_error_out,
    input logic signed [15:0] i_coef_readback
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_error_out) && $stable(i_coef_readback))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a word is in progress");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_out == 16'sd0 || i_coef_readback == 16'sd0))
        else $error("error and read-back both non-zero");
endmodule

bind nlms_adaptive_noise_canceller_top nanc_checker u_nanc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_error_out     (o_out.error_out),
    .i_coef_readback (o_out.coef_readback)
);

// ===== dv/nlms_adaptive_noise_canceller_top_test.sv =====
`timescale 1ns / 1ps
module nlms_adaptive_noise_canceller_top_test;
    import nanc_pkg::*;

    localparam int TAPS = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS = 750;

    // One row of the directed table. When has_exp is set, the expected result is
    // typed in here and compared as well as the prediction.
    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] sig;
        logic signed [15:0] nse;
        logic [7:0]         idx;
        logic signed [15:0] val;
        bit                 has_exp;
        logic signed [15:0] exp_err;
        logic signed [15:0] exp_rb;
    } t_row;

    typedef struct {
        logic signed [15:0] err;
        logic signed [15:0] rb;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic signed [15:0] i_cfg_data;

    nanc_in_if  in_ch ();
    nanc_out_if out_ch ();

    nlms_adaptive_noise_canceller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // The predictor's own copy of the filter state and the step size.
    logic signed [15:0] step_mu;
    logic signed [15:0] history [TAPS];
    logic signed [15:0] weights [TAPS];

    t_result expected_results [$];
    t_result typed_results [$];
    int  error_count;
    int  idle_cycles;
    bit  out_idling_on;
    bit  in_idling_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Work out the result of one accepted word and advance the predicted state.
    function automatic t_result predict_canceller(logic [1:0] cmd, logic signed [15:0] sig,
                                                  logic signed [15:0] nse, logic [7:0] idx,
                                                  logic signed [15:0] val);
        t_result r;
        longint acc;
        longint norm;
        longint delta;
        r.err = '0;
        r.rb  = '0;
        if (cmd == CMD_SAMPLE) begin
            for (int k = TAPS - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = nse;
            acc = 0;
            for (int k = 0; k < TAPS; k++)
                acc += longint'(weights[k]) * longint'(history[TAPS - 1 - k]);
            r.err = 16'(clamp16(longint'(sig) - clamp16(floor_shift(acc, 16))));
            norm = 0;
            for (int k = 0; k < TAPS; k++)
                norm += longint'(history[k]) * longint'(history[k]);
            norm = norm >>> 16;
            // With a zero norm the weights are left as they are.
            if (norm != 0) begin
                for (int k = 0; k < TAPS; k++) begin
                    delta = longint'(step_mu) * longint'(r.err) *
                            longint'(history[TAPS - 1 - k]);
                    delta = floor_shift(delta / norm, 14);
                    weights[k] = 16'(clamp16(longint'(weights[k]) + delta));
                end
            end
        end else if (cmd == CMD_WRITE) begin
            if (idx < TAPS) weights[idx] = val;
        end else if (cmd == CMD_READ) begin
            if (idx < TAPS) r.rb = weights[idx];
        end
        return r;
    endfunction

    // Result side: random back-pressure, and the comparison of every accepted word.
    always @(posedge i_clk) begin
        t_result want;
        t_result typed;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= out_idling_on ? ($urandom_range(99) >= 38) : 1'b1;
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result word with nothing expected: error_out=%0d coef_readback=%0d",
                           out_ch.error_out, out_ch.coef_readback);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    typed = typed_results.pop_front();
                    if (out_ch.error_out !== want.err || out_ch.error_out !== typed.err) begin
                        $error("error_out: expected %0d, got %0d", want.err, out_ch.error_out);
                        error_count++;
                    end
                    if (out_ch.coef_readback !== want.rb ||
                        out_ch.coef_readback !== typed.rb) begin
                        $error("coef_readback: expected %0d, got %0d",
                               want.rb, out_ch.coef_readback);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no word moving on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Present one word, with a random gap before it while input idling is on, and hold it until accepted.
    // Valid is left high on return so that a following word can go straight out;
    // the gap loop and wait_drained lower it.
    // The typed expectation, when given, is kept beside the prediction.
    task automatic send_word(t_row w);
        t_result p;
        if (in_idling_on) begin
            while ($urandom_range(99) < 38) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= w.cmd;
        in_ch.signal_sample <= w.sig;
        in_ch.noise_sample  <= w.nse;
        in_ch.coef_index    <= w.idx;
        in_ch.coef_value    <= w.val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        p = predict_canceller(w.cmd, w.sig, w.nse, w.idx, w.val);
        expected_results.push_back(p);
        typed_results.push_back(w.has_exp ? '{w.exp_err, w.exp_rb} : p);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the step size while the block is idle, in step with the predictor.
    task automatic write_step(logic signed [15:0] mu);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mu;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        step_mu = mu;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample(int spread);
        int s;
        case (spread)
            0: s = $urandom_range(65535) - 32768;
            1: s = $urandom_range(2047) - 1024;
            default: s = ($urandom_range(1)) ? 32767 : -32768;
        endcase
        return 16'(s);
    endfunction

    function automatic t_row random_row();
        t_row w;
        int pick;
        pick = $urandom_range(99);
        w.has_exp = 1'b0;
        w.exp_err = '0;
        w.exp_rb  = '0;
        w.sig = rand_sample($urandom_range(9) < 7 ? 0 : ($urandom_range(1) ? 1 : 2));
        w.nse = rand_sample($urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2));
        w.val = rand_sample($urandom_range(2));
        w.idx = ($urandom_range(9) < 8) ? 8'($urandom_range(TAPS - 1)) : 8'($urandom_range(255));
        // Mostly sample words, which is where the adaptation lives.
        if (pick < 70) w.cmd = CMD_SAMPLE;
        else if (pick < 82) w.cmd = CMD_WRITE;
        else if (pick < 96) w.cmd = CMD_READ;
        else w.cmd = CMD_UNUSED;
        // Now and then the reference sample is silent, which lowers the norm.
        if (pick < 8) w.nse = '0;
        return w;
    endfunction

    t_row directed [] = '{
        // After reset every weight reads zero and the error is the signal itself.
        '{CMD_READ,   16'sd0,      16'sd0,      8'd0,   16'sd0,      1, 16'sd0,      16'sd0},
        '{CMD_SAMPLE, 16'sd32767,  16'sd0,      8'd0,   16'sd0,      1, 16'sd32767,  16'sd0},
        '{CMD_SAMPLE, -16'sd32768, 16'sd0,      8'd0,   16'sd0,      1, -16'sd32768, 16'sd0},
        // Weight writes at both ends of the index range, and beyond it.
        '{CMD_WRITE,  16'sd0,      16'sd0,      8'd0,   16'sd32767,  1, 16'sd0,      16'sd0},
        '{CMD_WRITE,  16'sd0,      16'sd0,      8'd31,  -16'sd32768, 1, 16'sd0,      16'sd0},
        '{CMD_WRITE,  16'sd0,      16'sd0,      8'd32,  16'sd1234,   1, 16'sd0,      16'sd0},
        '{CMD_WRITE,  16'sd0,      16'sd0,      8'd255, 16'sd4321,   1, 16'sd0,      16'sd0},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd0,   16'sd0,      1, 16'sd0,      16'sd32767},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd31,  16'sd0,      1, 16'sd0,      -16'sd32768},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd32,  16'sd0,      1, 16'sd0,      16'sd0},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd255, 16'sd0,      1, 16'sd0,      16'sd0},
        // The unused command code changes nothing and returns zeros.
        '{CMD_UNUSED, 16'sd555,    16'sd777,    8'd3,   16'sd99,     1, 16'sd0,      16'sd0},
        // Full-scale reference samples, so the norm is large.
        '{CMD_SAMPLE, 16'sd32767,  -16'sd32768, 8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_SAMPLE, -16'sd32768, 16'sd32767,  8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_SAMPLE, 16'sd1000,   -16'sd32768, 8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        // A tiny reference, with the full-scale samples still in the history, so the norm stays above zero.
        '{CMD_SAMPLE, -16'sd5,     16'sd1,      8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd17,  16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_SAMPLE, 16'sd12345,  16'sd21845,  8'd0,   16'sd0,      0, 16'sd0,      16'sd0},
        '{CMD_READ,   16'sd0,      16'sd0,      8'd31,  16'sd0,      0, 16'sd0,      16'sd0}
    };

    logic signed [15:0] steps [] = '{16'sd33, 16'sd32767, -16'sd32768, 16'sd1, -16'sd7, 16'sd0};

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        out_idling_on = 1'b1;
        in_idling_on  = 1'b1;
        step_mu = STEP_RESET;
        foreach (history[k]) history[k] = '0;
        foreach (weights[k]) weights[k] = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd   = CMD_SAMPLE;
        in_ch.signal_sample = '0;
        in_ch.noise_sample  = '0;
        in_ch.coef_index    = '0;
        in_ch.coef_value    = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs with the reset step size.
        foreach (directed[i]) send_word(directed[i]);

        // The random part walks through several step sizes, the extremes included.
        // In the second phase neither side idles at all.
        foreach (steps[s]) begin
            write_step(steps[s]);
            in_idling_on  = (s != 1);
            out_idling_on = (s != 1);
            for (int n = 0; n < RANDOM_WORDS / steps.size(); n++) begin
                send_word(random_row());
                // Occasionally hold the sender back until everything has come out.
                if (n == 40) wait_drained();
            end
        end

        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
